// ===== sv/ibiu_pkg.sv =====
// ----------------------------------------------------------------------------
// ibiu_pkg
// Shared types and codes for the integer bit intrinsic unit.
// ----------------------------------------------------------------------------
package ibiu_pkg;

  // operation codes
  localparam logic [2:0] OP_ABS    = 3'd0;
  localparam logic [2:0] OP_POPCNT = 3'd1;
  localparam logic [2:0] OP_TZCNT  = 3'd2;
  localparam logic [2:0] OP_LZCNT  = 3'd3;
  localparam logic [2:0] OP_BSWAP  = 3'd4;
  localparam logic [2:0] OP_MIN    = 3'd5;
  localparam logic [2:0] OP_MAX    = 3'd6;

  // operand width codes
  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;
  localparam logic [1:0] WC_32 = 2'd2;
  localparam logic [1:0] WC_64 = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_OVERFLOW    = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  // most negative value of each width, as a 64-bit pattern (sign bit only)
  localparam logic [63:0] SIGN_BIT_8  = 64'h0000_0000_0000_0080;
  localparam logic [63:0] SIGN_BIT_16 = 64'h0000_0000_0000_8000;
  localparam logic [63:0] SIGN_BIT_32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] SIGN_BIT_64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  width_code;
    logic        is_signed;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [1:0]  status;
  } out_rsp_t;

endpackage

// ===== sv/integer_bit_intrinsic_unit_core.sv =====
// ----------------------------------------------------------------------------
// integer_bit_intrinsic_unit_core
// Abs, popcount, zero counts, byte swap and min/max on 8..64-bit integers.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with an in_req struct (operation,
//   width code, signedness, two operands). Each request yields exactly one
//   response on out_valid/out_ready: the result in the low width bits with
//   the upper bits zero, plus a status code.
//   A request passes the request register, then the datapath into the
//   response register; out_valid rises once the response lands there.
//   A request can wait in the request register while the receiver stalls.
//   Throughput is one request per cycle while the receiver takes responses;
//   the datapath between the two registers is combinational.
//   in_ready stays high while either register has room, or while the
//   receiver takes the current response; a stalled receiver fills both
//   registers and then holds in_ready low, with no request lost.
//   Reset (rst_n low, synchronous) empties both registers.
// ----------------------------------------------------------------------------
module integer_bit_intrinsic_unit_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ibiu_pkg::in_req_t   in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output ibiu_pkg::out_rsp_t  out_rsp
);

  logic                s1_v_r, s1_v_nxt;
  ibiu_pkg::in_req_t   s1_req_r;
  logic                out_v_r, out_v_nxt;
  ibiu_pkg::out_rsp_t  out_rsp_r, out_rsp_nxt;

  logic in_fire, s1_fire, out_fire;

  logic [63:0] mask, sign, a, b, neg, ka, kb;
  logic [63:0] tz_vec, a_left, rev, lz_vec, pc_in, bswap;
  logic [5:0]  shl;
  logic        a_neg, a_less;
  logic [6:0]  pc;

  assign out_fire = out_v_r & out_ready;
  assign s1_fire  = s1_v_r & (~out_v_r | out_ready);
  assign in_ready = ~s1_v_r | ~out_v_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  assign out_valid = out_v_r;
  assign out_rsp   = out_rsp_r;

  // width-dependent masks
  always_comb begin
    case (s1_req_r.width_code)
      ibiu_pkg::WC_8: begin
        mask = 64'h0000_0000_0000_00FF;
        sign = ibiu_pkg::SIGN_BIT_8;
        shl  = 6'd56;
      end
      ibiu_pkg::WC_16: begin
        mask = 64'h0000_0000_0000_FFFF;
        sign = ibiu_pkg::SIGN_BIT_16;
        shl  = 6'd48;
      end
      ibiu_pkg::WC_32: begin
        mask = 64'h0000_0000_FFFF_FFFF;
        sign = ibiu_pkg::SIGN_BIT_32;
        shl  = 6'd32;
      end
      default: begin
        mask = 64'hFFFF_FFFF_FFFF_FFFF;
        sign = ibiu_pkg::SIGN_BIT_64;
        shl  = 6'd0;
      end
    endcase
  end

  assign a     = s1_req_r.operand_a & mask;
  assign b     = s1_req_r.operand_b & mask;
  assign neg   = (64'd0 - a) & mask;
  assign a_neg = |(a & sign);

  // signed compare: flip the sign bit, then compare unsigned
  assign ka     = s1_req_r.is_signed ? (a ^ sign) : a;
  assign kb     = s1_req_r.is_signed ? (b ^ sign) : b;
  assign a_less = ka < kb;

  // zero counts become popcounts: bits below the lowest set bit.
  // a zero input counts every bit in the width.
  assign tz_vec = ~a & (a - 64'd1) & mask;
  assign a_left = a << shl;

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      rev[i] = a_left[63 - i];
    end
  end

  assign lz_vec = ~rev & (rev - 64'd1) & mask;

  always_comb begin
    case (s1_req_r.operation)
      ibiu_pkg::OP_TZCNT: pc_in = tz_vec;
      ibiu_pkg::OP_LZCNT: pc_in = lz_vec;
      default:            pc_in = a;
    endcase
  end

  assign pc = 7'($countones(pc_in));

  always_comb begin
    case (s1_req_r.width_code)
      ibiu_pkg::WC_16: bswap = {48'd0, a[7:0], a[15:8]};
      ibiu_pkg::WC_32: bswap = {32'd0, a[7:0], a[15:8], a[23:16], a[31:24]};
      ibiu_pkg::WC_64: bswap = {a[7:0], a[15:8], a[23:16], a[31:24],
                                a[39:32], a[47:40], a[55:48], a[63:56]};
      default:         bswap = 64'd0;
    endcase
  end

  always_comb begin
    out_rsp_nxt.result_value = 64'd0;
    out_rsp_nxt.status       = ibiu_pkg::ST_OK;
    case (s1_req_r.operation)
      ibiu_pkg::OP_ABS: begin
        if (!s1_req_r.is_signed) begin
          out_rsp_nxt.status = ibiu_pkg::ST_UNSUPPORTED;
        end else if (a_neg) begin
          out_rsp_nxt.result_value = neg;
          if (a == sign) out_rsp_nxt.status = ibiu_pkg::ST_OVERFLOW;
        end else begin
          out_rsp_nxt.result_value = a;
        end
      end
      ibiu_pkg::OP_POPCNT,
      ibiu_pkg::OP_TZCNT,
      ibiu_pkg::OP_LZCNT: out_rsp_nxt.result_value = {57'd0, pc};
      ibiu_pkg::OP_BSWAP: begin
        if (s1_req_r.width_code == ibiu_pkg::WC_8) begin
          out_rsp_nxt.status = ibiu_pkg::ST_UNSUPPORTED;
        end else begin
          out_rsp_nxt.result_value = bswap;
        end
      end
      ibiu_pkg::OP_MIN: out_rsp_nxt.result_value = a_less ? a : b;
      ibiu_pkg::OP_MAX: out_rsp_nxt.result_value = a_less ? b : a;
      default:          out_rsp_nxt.status = ibiu_pkg::ST_UNSUPPORTED;
    endcase
  end

  always_comb begin
    s1_v_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_v_r);
    out_v_nxt = s1_fire ? 1'b1 : (out_fire ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_req_r <= in_req;
    if (s1_fire) out_rsp_r <= out_rsp_nxt;
  end

  // an accepted request always lands in the request register
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_v_r)
    else $error("accepted request not held in request register");

  // a held request moves forward when the response register is empty
  a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_v_r |=> out_v_r)
    else $error("request stuck with empty response register");

  // overflow only for abs of the most negative value, which wraps to itself
  a_ovf_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_rsp_r.status == ibiu_pkg::ST_OVERFLOW
      |-> $onehot(out_rsp_r.result_value))
    else $error("overflow response without single sign bit value");

  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_rsp_r.status == ibiu_pkg::ST_UNSUPPORTED
      |-> out_rsp_r.result_value == 64'd0)
    else $error("unsupported response with nonzero value");

endmodule

// ===== bench/integer_bit_intrinsic_unit_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_bit_intrinsic_unit_core_tb
// Sends abs, popcount, zero-count, byte-swap and min/max requests at every
// operand width, computes each expected response in the bench and compares
// responses in order. Runs directed corners, random traffic with random gaps
// on both sides, a back-to-back burst and a long receiver hold-off.
// ----------------------------------------------------------------------------
module integer_bit_intrinsic_unit_core_tb;

  localparam logic [2:0] OP_UNKNOWN      = 3'd7;
  localparam int         HOLD_OFF_CYCLES = 64;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  ibiu_pkg::in_req_t  in_req;
  logic               out_valid;
  logic               out_ready;
  ibiu_pkg::out_rsp_t out_rsp;

  ibiu_pkg::out_rsp_t expected_rsp_q[$];
  int                 mismatch_count;
  bit                 sender_gaps_on;
  bit                 receiver_stalls_on;
  bit                 hold_off_req;

  integer_bit_intrinsic_unit_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // sign bit of the operand width, as a 64-bit pattern
  function automatic logic [63:0] sign_pattern(input logic [1:0] wc);
    case (wc)
      ibiu_pkg::WC_8:  return ibiu_pkg::SIGN_BIT_8;
      ibiu_pkg::WC_16: return ibiu_pkg::SIGN_BIT_16;
      ibiu_pkg::WC_32: return ibiu_pkg::SIGN_BIT_32;
      default:         return ibiu_pkg::SIGN_BIT_64;
    endcase
  endfunction

  function automatic ibiu_pkg::out_rsp_t predict_intrinsic(input ibiu_pkg::in_req_t r);
    int unsigned        nbits;
    int                 i;
    logic [63:0]        sign_bit;
    logic [63:0]        mask;
    logic [63:0]        a;
    logic [63:0]        b;
    logic [63:0]        ka;
    logic [63:0]        kb;
    logic [63:0]        res;
    logic [1:0]         st;
    ibiu_pkg::out_rsp_t rsp;
    nbits    = 8 << r.width_code;
    sign_bit = sign_pattern(r.width_code);
    mask     = (sign_bit << 1) - 64'd1;  // wraps to all ones at 64 bits
    a        = r.operand_a & mask;
    b        = r.operand_b & mask;
    res      = '0;
    st       = ibiu_pkg::ST_OK;
    case (r.operation)
      ibiu_pkg::OP_ABS: begin
        if (!r.is_signed) begin
          st = ibiu_pkg::ST_UNSUPPORTED;
        end else if ((a & sign_bit) != 0) begin
          res = (64'd0 - a) & mask;
          if (a == sign_bit) st = ibiu_pkg::ST_OVERFLOW;
        end else begin
          res = a;
        end
      end
      ibiu_pkg::OP_POPCNT: begin
        for (i = 0; i < 64; i++) res = res + 64'(a[i]);
      end
      ibiu_pkg::OP_TZCNT: begin
        res = 64'(nbits);
        for (i = nbits - 1; i >= 0; i--) if (a[i]) res = 64'(i);
      end
      ibiu_pkg::OP_LZCNT: begin
        res = 64'(nbits);
        for (i = 0; i < nbits; i++) if (a[i]) res = 64'(nbits - 1 - i);
      end
      ibiu_pkg::OP_BSWAP: begin
        if (r.width_code == ibiu_pkg::WC_8) begin
          st = ibiu_pkg::ST_UNSUPPORTED;
        end else begin
          for (i = 0; i < nbits / 8; i++) res[8 * (nbits / 8 - 1 - i) +: 8] = a[8 * i +: 8];
        end
      end
      ibiu_pkg::OP_MIN, ibiu_pkg::OP_MAX: begin
        // flip the sign bit so a signed compare becomes unsigned
        ka = r.is_signed ? (a ^ sign_bit) : a;
        kb = r.is_signed ? (b ^ sign_bit) : b;
        if (r.operation == ibiu_pkg::OP_MIN) res = (ka < kb) ? a : b;
        else                                 res = (ka < kb) ? b : a;
      end
      default: begin
        st = ibiu_pkg::ST_UNSUPPORTED;
      end
    endcase
    rsp.result_value = res & mask;
    rsp.status       = st;
    return rsp;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic ibiu_pkg::in_req_t make_req(input logic [2:0] op,
                                                 input logic [1:0] wc,
                                                 input logic sgn,
                                                 input logic [63:0] a,
                                                 input logic [63:0] b);
    ibiu_pkg::in_req_t r;
    r.operation  = op;
    r.width_code = wc;
    r.is_signed  = sgn;
    r.operand_a  = a;
    r.operand_b  = b;
    return r;
  endfunction

  // operand with a shape chosen to hit corners, upper bits sometimes dirty
  function automatic logic [63:0] random_operand(input logic [1:0] wc);
    logic [63:0] sign_bit;
    logic [63:0] mask;
    logic [63:0] v;
    sign_bit = sign_pattern(wc);
    mask     = (sign_bit << 1) - 64'd1;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = sign_bit;
      3:       v = sign_bit + 64'd1;
      4:       v = sign_bit - 64'd1;
      5:       v = 64'd1 << $urandom_range(0, 63);
      6:       v = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 1) == 0) v = v & mask;
    else                           v = (v & mask) | ({$urandom, $urandom} & ~mask);
    return v;
  endfunction

  function automatic ibiu_pkg::in_req_t random_request();
    ibiu_pkg::in_req_t r;
    r.operation  = ($urandom_range(0, 39) == 0) ? OP_UNKNOWN : 3'($urandom_range(0, 6));
    r.width_code = 2'($urandom_range(0, 3));
    if (r.operation == ibiu_pkg::OP_ABS) r.is_signed = ($urandom_range(0, 7) != 0);
    else                                 r.is_signed = 1'($urandom_range(0, 1));
    r.operand_a = random_operand(r.width_code);
    if ($urandom_range(0, 7) == 0) r.operand_b = r.operand_a;
    else                           r.operand_b = random_operand(r.width_code);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // caller stands just after a rising edge; returns just after acceptance
  task automatic send_request(input ibiu_pkg::in_req_t r);
    int gap;
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    expected_rsp_q.push_back(predict_intrinsic(r));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!receiver_stalls_on) stall_left = 0;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (receiver_stalls_on && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // response checker
  always @(posedge clk) begin
    ibiu_pkg::out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending: value %h status %0d",
                                  out_rsp.result_value, out_rsp.status));
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_rsp.result_value !== want.result_value)
          report_mismatch($sformatf("result_value %h, want %h",
                                    out_rsp.result_value, want.result_value));
        if (out_rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_rsp.status, want.status));
      end
    end
  end

  task automatic test_directed_corners();
    send_request(make_req(ibiu_pkg::OP_ABS, ibiu_pkg::WC_8, 1'b1,
                          ibiu_pkg::SIGN_BIT_8, '0));
    send_request(make_req(ibiu_pkg::OP_ABS, ibiu_pkg::WC_64, 1'b1,
                          ibiu_pkg::SIGN_BIT_64, '1));
    send_request(make_req(ibiu_pkg::OP_ABS, ibiu_pkg::WC_16, 1'b1,
                          64'hFFFF_FFFF_FFFF_FFFF, '0));
    send_request(make_req(ibiu_pkg::OP_ABS, ibiu_pkg::WC_32, 1'b0,
                          64'h0000_0000_8000_0001, '0));
    send_request(make_req(ibiu_pkg::OP_ABS, ibiu_pkg::WC_32, 1'b1,
                          64'hDEAD_BEEF_7FFF_FFFF, '0));
    send_request(make_req(ibiu_pkg::OP_POPCNT, ibiu_pkg::WC_64, 1'b0, '1, '0));
    send_request(make_req(ibiu_pkg::OP_POPCNT, ibiu_pkg::WC_8, 1'b1, '1, '1));
    send_request(make_req(ibiu_pkg::OP_TZCNT, ibiu_pkg::WC_32, 1'b0,
                          64'hFFFF_FFFF_0000_0000, '0));
    send_request(make_req(ibiu_pkg::OP_TZCNT, ibiu_pkg::WC_64, 1'b0,
                          ibiu_pkg::SIGN_BIT_64, '0));
    send_request(make_req(ibiu_pkg::OP_TZCNT, ibiu_pkg::WC_8, 1'b0,
                          64'h0000_0000_0000_0001, '0));
    send_request(make_req(ibiu_pkg::OP_LZCNT, ibiu_pkg::WC_16, 1'b0,
                          64'hFFFF_FFFF_FFFF_0000, '0));
    send_request(make_req(ibiu_pkg::OP_LZCNT, ibiu_pkg::WC_8, 1'b1,
                          64'h0000_0000_0000_0001, '0));
    send_request(make_req(ibiu_pkg::OP_LZCNT, ibiu_pkg::WC_64, 1'b0, '0, '0));
    send_request(make_req(ibiu_pkg::OP_BSWAP, ibiu_pkg::WC_8, 1'b0,
                          64'h0000_0000_0000_00A5, '0));
    send_request(make_req(ibiu_pkg::OP_BSWAP, ibiu_pkg::WC_16, 1'b0,
                          64'h1122_3344_5566_7788, '0));
    send_request(make_req(ibiu_pkg::OP_BSWAP, ibiu_pkg::WC_32, 1'b1,
                          64'h1122_3344_5566_7788, '0));
    send_request(make_req(ibiu_pkg::OP_BSWAP, ibiu_pkg::WC_64, 1'b0,
                          64'h0102_0304_0506_0708, '0));
    send_request(make_req(ibiu_pkg::OP_MIN, ibiu_pkg::WC_8, 1'b1,
                          64'h0000_0000_0000_0080, 64'h0000_0000_0000_007F));
    send_request(make_req(ibiu_pkg::OP_MIN, ibiu_pkg::WC_16, 1'b0,
                          64'h0000_0000_0000_8000, 64'h0000_0000_0000_7FFF));
    send_request(make_req(ibiu_pkg::OP_MAX, ibiu_pkg::WC_64, 1'b0, '1, '0));
    send_request(make_req(ibiu_pkg::OP_MAX, ibiu_pkg::WC_64, 1'b1, '1, '0));
    send_request(make_req(ibiu_pkg::OP_MAX, ibiu_pkg::WC_32, 1'b1,
                          64'h1234_5678_8000_0000, 64'h0000_0000_8000_0000));
    send_request(make_req(OP_UNKNOWN, ibiu_pkg::WC_64, 1'b1, '1, '1));
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int count);
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    repeat (count) send_request(random_request());
    wait_for_drain();
  endtask

  task automatic test_back_to_back(input int count);
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    repeat (count) send_request(random_request());
    wait_for_drain();
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_output_hold_off(input int count);
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b1;
    hold_off_req       = 1'b1;
    repeat (count) send_request(random_request());
    wait_for_drain();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_req             = '0;
    mismatch_count     = 0;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    hold_off_req       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_traffic(1000);
    test_back_to_back(300);
    test_output_hold_off(60);
    test_random_traffic(300);
    test_output_hold_off(60);
    test_random_traffic(110);

    repeat (10) @(posedge clk);
    if (expected_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_rsp_q.size()));
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== integer_bit_intrinsic_unit_core.f =====
sv/ibiu_pkg.sv
sv/integer_bit_intrinsic_unit_core.sv
bench/integer_bit_intrinsic_unit_core_tb.sv
